FILE: sv/swca_pkg.sv
// Shared constants and types for the segment to wire closest approach block.
`default_nettype none
package swca_pkg;

  localparam int IN_FIELDS = 12;

  typedef struct packed {
    logic par;
    logic wire_zero;
    logic seg_done;
    logic seg_one;
    logic wire_done;
    logic wire_one;
  } swca_flags_t;

endpackage
`default_nettype wire

FILE: sv/swca_front.sv
// Difference vectors, the fifteen coordinate products and the five dot products.
`default_nettype none
module swca_front #(
  parameter int C  = 24,
  parameter int DW = C + 1,
  parameter int SW = 2 * DW + 2
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [swca_pkg::IN_FIELDS-1:0][C-1:0]  coord,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [SW-1:0]                        dot_a,
  output logic signed [SW-1:0]                        dot_b,
  output logic signed [SW-1:0]                        dot_c,
  output logic signed [SW-1:0]                        dot_d,
  output logic signed [SW-1:0]                        dot_e
);
  import swca_pkg::*;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic signed [DW-1:0] s [3];
  logic signed [DW-1:0] d [3];
  logic signed [DW-1:0] r [3];
  logic signed [2*DW-1:0] pss [3];
  logic signed [2*DW-1:0] psr [3];
  logic signed [2*DW-1:0] prr [3];
  logic signed [2*DW-1:0] psd [3];
  logic signed [2*DW-1:0] prd [3];

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int k = 0; k < 3; k++) begin
        s[k] <= DW'($signed(coord[3+k])) - DW'($signed(coord[k]));
        d[k] <= DW'($signed(coord[k])) - DW'($signed(coord[6+k]));
        r[k] <= DW'($signed(coord[9+k]));
      end
    end
    if (rdy2) begin
      for (int k = 0; k < 3; k++) begin
        pss[k] <= s[k] * s[k];
        psr[k] <= s[k] * r[k];
        prr[k] <= r[k] * r[k];
        psd[k] <= s[k] * d[k];
        prd[k] <= r[k] * d[k];
      end
    end
    if (rdy3) begin
      dot_a <= SW'(pss[0]) + SW'(pss[1]) + SW'(pss[2]);
      dot_b <= SW'(psr[0]) + SW'(psr[1]) + SW'(psr[2]);
      dot_c <= SW'(prr[0]) + SW'(prr[1]) + SW'(prr[2]);
      dot_d <= SW'(psd[0]) + SW'(psd[1]) + SW'(psd[2]);
      dot_e <= SW'(prd[0]) + SW'(prd[1]) + SW'(prd[2]);
    end
  end

endmodule
`default_nettype wire

FILE: sv/swca_wmul.sv
// Two stage signed multiplier built from four half width partial products.
`default_nettype none
module swca_wmul #(
  parameter int W = 52
) (
  input  wire logic                  clk,
  input  wire logic [1:0]            en,
  input  wire logic signed [W-1:0]   a,
  input  wire logic signed [W-1:0]   b,
  output logic signed [2*W-1:0]      p
);
  localparam int HW = (W + 1) / 2;
  localparam int TW = W - HW;

  logic [HW-1:0]          al, bl;
  logic signed [TW-1:0]   ah, bh;
  logic [2*HW-1:0]        ll;
  logic signed [HW+TW:0]  lh, hl;
  logic signed [2*TW-1:0] hh;
  logic signed [2*W-1:0]  t0, t1, t2, t3;

  assign al = a[HW-1:0];
  assign bl = b[HW-1:0];
  assign ah = a[W-1:HW];
  assign bh = b[W-1:HW];

  assign t0 = $signed((2*W)'(ll));
  assign t1 = $signed((2*W)'(lh)) <<< HW;
  assign t2 = $signed((2*W)'(hl)) <<< HW;
  assign t3 = $signed((2*W)'(hh)) <<< (2 * HW);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ll <= al * bl;
      lh <= $signed({1'b0, al}) * bh;
      hl <= ah * $signed({1'b0, bl});
      hh <= ah * bh;
    end
    if (en[1]) begin
      p <= t0 + t1 + t2 + t3;
    end
  end

endmodule
`default_nettype wire

FILE: sv/swca_cross.sv
// Products of dot products, the determinant, the two quotient numerators and the parallel fallback terms.
`default_nettype none
module swca_cross #(
  parameter int SW = 52,
  parameter int MW = 2 * SW + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [SW-1:0] dot_a,
  input  wire logic signed [SW-1:0] dot_b,
  input  wire logic signed [SW-1:0] dot_c,
  input  wire logic signed [SW-1:0] dot_d,
  input  wire logic signed [SW-1:0] dot_e,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [MW-1:0]      det,
  output logic signed [MW-1:0]      num_seg,
  output logic signed [MW-1:0]      num_wire,
  output logic signed [SW+1:0]      mid_num,
  output logic signed [SW:0]        mid_den,
  output logic                      wire_zero
);
  import swca_pkg::*;

  logic v4, v5, v6;
  logic rdy4, rdy5, rdy6;
  logic signed [2*SW-1:0] ac, bb, be, cd, ae, bd;
  logic signed [SW+1:0] pe4, pe5;
  logic signed [SW:0]   pc4, pc5;
  logic cz4, cz5;

  assign rdy6      = !v6 || out_ready;
  assign rdy5      = !v5 || rdy6;
  assign rdy4      = !v4 || rdy5;
  assign in_ready  = rdy4;
  assign out_valid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy4) v4 <= in_valid;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  swca_wmul #(.W(SW)) u_ac (.clk(clk), .en({rdy5, rdy4}), .a(dot_a), .b(dot_c), .p(ac));
  swca_wmul #(.W(SW)) u_bb (.clk(clk), .en({rdy5, rdy4}), .a(dot_b), .b(dot_b), .p(bb));
  swca_wmul #(.W(SW)) u_be (.clk(clk), .en({rdy5, rdy4}), .a(dot_b), .b(dot_e), .p(be));
  swca_wmul #(.W(SW)) u_cd (.clk(clk), .en({rdy5, rdy4}), .a(dot_c), .b(dot_d), .p(cd));
  swca_wmul #(.W(SW)) u_ae (.clk(clk), .en({rdy5, rdy4}), .a(dot_a), .b(dot_e), .p(ae));
  swca_wmul #(.W(SW)) u_bd (.clk(clk), .en({rdy5, rdy4}), .a(dot_b), .b(dot_d), .p(bd));

  always_ff @(posedge clk) begin
    if (rdy4) begin
      pe4 <= (SW+2)'(dot_e) + (SW+2)'(dot_e) + (SW+2)'(dot_b);
      pc4 <= (SW+1)'(dot_c) + (SW+1)'(dot_c);
      cz4 <= (dot_c == '0);
    end
    if (rdy5) begin
      pe5 <= pe4;
      pc5 <= pc4;
      cz5 <= cz4;
    end
    if (rdy6) begin
      det       <= MW'(ac) - MW'(bb);
      num_seg   <= MW'(be) - MW'(cd);
      num_wire  <= MW'(ae) - MW'(bd);
      mid_num   <= pe5;
      mid_den   <= pc5;
      wire_zero <= cz5;
    end
  end

endmodule
`default_nettype wire

FILE: sv/swca_div.sv
// Parallel test, sign fix, clamping and the bit per stage restoring dividers.
`default_nettype none
module swca_div #(
  parameter int SW = 52,
  parameter int MW = 2 * SW + 1,
  parameter int F  = 16,
  parameter int QW = F + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [31:0]          threshold,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [MW-1:0] det,
  input  wire logic signed [MW-1:0] num_seg,
  input  wire logic signed [MW-1:0] num_wire,
  input  wire logic signed [SW+1:0] mid_num,
  input  wire logic signed [SW:0]   mid_den,
  input  wire logic                 wire_zero,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [QW-1:0]             seg_param,
  output logic [QW-1:0]             wire_param,
  output logic                      par_flag
);
  import swca_pkg::*;

  localparam int NW = MW + 1;
  localparam int L  = F + 4;
  localparam logic [QW-1:0] ONE  = QW'(1) << F;
  localparam logic [QW-1:0] HALF = QW'(1) << (F - 1);

  logic [L-1:0] v;
  logic [L:0]   rdy;

  logic signed [NW-1:0] det_e, thr_e;
  logic                 par_c;
  logic                 par7, cz7, par8, cz8;
  logic signed [NW-1:0] nt7, dt7, nw7, dw7;
  logic signed [NW-1:0] nt8, dt8, nw8, dw8;

  logic [NW-1:0] rem_t [F+1];
  logic [NW-1:0] rem_w [F+1];
  logic [NW-1:0] den_t [F+1];
  logic [NW-1:0] den_w [F+1];
  logic [F-1:0]  q_t   [F+1];
  logic [F-1:0]  q_w   [F+1];
  swca_flags_t   fl    [F+1];

  assign rdy[L] = out_ready;
  genvar g;
  generate
    for (g = 0; g < L; g++) begin : g_rdy
      assign rdy[g] = !v[g] || rdy[g+1];
    end
  endgenerate
  assign in_ready  = rdy[0];
  assign out_valid = v[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < L; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  assign det_e = NW'(det);
  assign thr_e = $signed(NW'(threshold));
  assign par_c = (det_e <= thr_e) && (det_e >= -thr_e);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      par7 <= par_c;
      cz7  <= wire_zero;
      nt7  <= NW'(num_seg);
      dt7  <= det_e;
      nw7  <= par_c ? NW'(mid_num) : NW'(num_wire);
      dw7  <= par_c ? NW'(mid_den) : det_e;
    end
    if (rdy[1]) begin
      par8 <= par7;
      cz8  <= cz7;
      nt8  <= dt7[NW-1] ? -nt7 : nt7;
      dt8  <= dt7[NW-1] ? -dt7 : dt7;
      nw8  <= dw7[NW-1] ? -nw7 : nw7;
      dw8  <= dw7[NW-1] ? -dw7 : dw7;
    end
    if (rdy[2]) begin
      fl[0].par       <= par8;
      fl[0].wire_zero <= cz8;
      fl[0].seg_done  <= (nt8 <= 0) || (nt8 >= dt8);
      fl[0].seg_one   <= (nt8 > 0) && (nt8 >= dt8);
      fl[0].wire_done <= (nw8 <= 0) || (nw8 >= dw8);
      fl[0].wire_one  <= (nw8 > 0) && (nw8 >= dw8);
      rem_t[0] <= nt8;
      rem_w[0] <= nw8;
      den_t[0] <= dt8;
      den_w[0] <= dw8;
      q_t[0]   <= '0;
      q_w[0]   <= '0;
    end
  end

  generate
    for (g = 0; g < F; g++) begin : g_step
      logic [NW-1:0] r2_t, r2_w;
      logic          ge_t, ge_w;
      assign r2_t = {rem_t[g][NW-2:0], 1'b0};
      assign r2_w = {rem_w[g][NW-2:0], 1'b0};
      assign ge_t = r2_t >= den_t[g];
      assign ge_w = r2_w >= den_w[g];
      always_ff @(posedge clk) begin
        if (rdy[3+g]) begin
          rem_t[g+1] <= ge_t ? r2_t - den_t[g] : r2_t;
          rem_w[g+1] <= ge_w ? r2_w - den_w[g] : r2_w;
          den_t[g+1] <= den_t[g];
          den_w[g+1] <= den_w[g];
          q_t[g+1]   <= {q_t[g][F-2:0], ge_t};
          q_w[g+1]   <= {q_w[g][F-2:0], ge_w};
          fl[g+1]    <= fl[g];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rdy[L-1]) begin
      par_flag <= fl[F].par;
      if (fl[F].par) begin
        seg_param <= HALF;
      end else if (fl[F].seg_done) begin
        seg_param <= fl[F].seg_one ? ONE : '0;
      end else begin
        seg_param <= QW'(q_t[F]);
      end
      if (fl[F].wire_zero) begin
        wire_param <= ONE;
      end else if (fl[F].wire_done) begin
        wire_param <= fl[F].wire_one ? ONE : '0;
      end else begin
        wire_param <= QW'(q_w[F]);
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/segment_wire_closest_approach.sv
// Top level of the segment to wire closest approach pipeline.
//
// Each input word on the s_axis channel carries one track segment (start and
// stop points) and one wire (head point and direction vector), twelve signed
// coordinates packed from the lowest bit up. Each output word on m_axis holds
// the clamped segment and wire parameters in tdata and the parallel flag in
// tuser. The parallel threshold is written through the cfg channel, which is
// always ready; write it only while no words are in flight.
// The pipeline takes one word per cycle while m_axis accepts results and gives one
// result per word. Its stages are three of dot products, three of wide products
// and differences, four of selection, sign fixing, clamping and output, and one
// stage per fraction bit in the two restoring dividers.
// Every stage holds its own valid bit, so a stall at m_axis fills the empty
// stages first and s_axis_tready falls only once the pipeline is full; no
// word is dropped or repeated. Reset empties the pipeline and sets the
// threshold to zero.
`default_nettype none
module segment_wire_closest_approach #(
  parameter int COORD_BITS      = 24,
  parameter int PARAM_FRAC_BITS = 16,
  localparam int IW = ((swca_pkg::IN_FIELDS * COORD_BITS + 7) / 8) * 8,
  localparam int OW = ((2 * (PARAM_FRAC_BITS + 1) + 7) / 8) * 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [31:0]   cfg_data,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // seg_start_x/y/z, seg_stop_x/y/z, wire_head_x/y/z, wire_dir_x/y/z
  input  wire logic [IW-1:0] s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // seg_param, wire_param
  output logic [OW-1:0]      m_axis_tdata,
  // parallel_flag
  output logic [0:0]         m_axis_tuser
);
  import swca_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int SW = 2 * DW + 2;
  localparam int MW = 2 * SW + 1;
  localparam int QW = PARAM_FRAC_BITS + 1;

  logic [31:0] threshold;
  logic [IN_FIELDS-1:0][COORD_BITS-1:0] coord;

  logic                 f_valid, f_ready;
  logic signed [SW-1:0] dot_a, dot_b, dot_c, dot_d, dot_e;
  logic                 x_valid, x_ready;
  logic signed [MW-1:0] det, num_seg, num_wire;
  logic signed [SW+1:0] mid_num;
  logic signed [SW:0]   mid_den;
  logic                 wire_zero;
  logic [QW-1:0]        seg_param, wire_param;
  logic                 par_flag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  always_comb begin
    for (int k = 0; k < IN_FIELDS; k++) begin
      coord[k] = s_axis_tdata[k*COORD_BITS +: COORD_BITS];
    end
  end

  swca_front #(.C(COORD_BITS), .DW(DW), .SW(SW)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .coord(coord),
    .out_valid(f_valid), .out_ready(f_ready),
    .dot_a(dot_a), .dot_b(dot_b), .dot_c(dot_c), .dot_d(dot_d), .dot_e(dot_e)
  );

  swca_cross #(.SW(SW), .MW(MW)) u_cross (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready),
    .dot_a(dot_a), .dot_b(dot_b), .dot_c(dot_c), .dot_d(dot_d), .dot_e(dot_e),
    .out_valid(x_valid), .out_ready(x_ready),
    .det(det), .num_seg(num_seg), .num_wire(num_wire),
    .mid_num(mid_num), .mid_den(mid_den), .wire_zero(wire_zero)
  );

  swca_div #(.SW(SW), .MW(MW), .F(PARAM_FRAC_BITS), .QW(QW)) u_div (
    .clk(clk), .rst(rst), .threshold(threshold),
    .in_valid(x_valid), .in_ready(x_ready),
    .det(det), .num_seg(num_seg), .num_wire(num_wire),
    .mid_num(mid_num), .mid_den(mid_den), .wire_zero(wire_zero),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .seg_param(seg_param), .wire_param(wire_param), .par_flag(par_flag)
  );

  assign m_axis_tdata = OW'({wire_param, seg_param});
  assign m_axis_tuser = par_flag;

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the segment to wire closest approach pipeline.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 24;
  localparam int FB = 16;
  localparam int IW = ((12 * CB + 7) / 8) * 8;
  localparam int OW = ((2 * (FB + 1) + 7) / 8) * 8;
  localparam int LATENCY = FB + 10;
  localparam int N_RANDOM = 1400;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [FB:0] ONE = 1 << FB;
  localparam logic [FB:0] HALF = 1 << (FB - 1);

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [255:0] wide_t;

  typedef struct {
    coord_t f[12];
  } track_wire_t;

  typedef struct {
    logic [FB:0] seg_param;
    logic [FB:0] wire_param;
    logic parallel_flag;
  } approach_t;

  typedef struct {
    track_wire_t item;
    logic check_typed;
    approach_t typed;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [31:0] cfg_data = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OW-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  logic [31:0] threshold = 0;
  approach_t expected_q[$];
  int errors = 0;
  int checked = 0;
  int parallel_seen = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  row_t rows[$];

  segment_wire_closest_approach dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [FB:0] clamp_quotient(wide_t num, wide_t den);
    wide_t q;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num <= 0) return 0;
    if (num >= den) return ONE;
    q = (num <<< FB) / den;
    return q[FB:0];
  endfunction

  function automatic approach_t closest_approach(track_wire_t it, logic [31:0] thr);
    wide_t s[3], d[3], r[3];
    wide_t a, b, c, dd, e, det, mag;
    approach_t res;
    for (int k = 0; k < 3; k++) begin
      s[k] = wide_t'(it.f[3+k]) - wide_t'(it.f[k]);
      d[k] = wide_t'(it.f[k]) - wide_t'(it.f[6+k]);
      r[k] = wide_t'(it.f[9+k]);
    end
    a = s[0]*s[0] + s[1]*s[1] + s[2]*s[2];
    b = s[0]*r[0] + s[1]*r[1] + s[2]*r[2];
    c = r[0]*r[0] + r[1]*r[1] + r[2]*r[2];
    dd = s[0]*d[0] + s[1]*d[1] + s[2]*d[2];
    e = r[0]*d[0] + r[1]*d[1] + r[2]*d[2];
    det = a*c - b*b;
    mag = (det < 0) ? -det : det;
    if (mag <= wide_t'({1'b0, thr})) begin
      res.parallel_flag = 1;
      res.seg_param = HALF;
      res.wire_param = (c == 0) ? ONE : clamp_quotient(2*e + b, 2*c);
    end else begin
      res.parallel_flag = 0;
      res.seg_param = clamp_quotient(b*e - c*dd, det);
      res.wire_param = clamp_quotient(a*e - b*dd, det);
    end
    return res;
  endfunction

  function automatic logic [IW-1:0] pack_item(track_wire_t it);
    logic [IW-1:0] v = '0;
    for (int k = 0; k < 12; k++) v[k*CB +: CB] = it.f[k];
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("Mismatch on result %0d: %s got %0d expected %0d", checked, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    approach_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[FB:0] !== want.seg_param)
          report_mismatch("seg_param", m_axis_tdata[FB:0], want.seg_param);
        if (m_axis_tdata[2*FB+1:FB+1] !== want.wire_param)
          report_mismatch("wire_param", m_axis_tdata[2*FB+1:FB+1], want.wire_param);
        if (m_axis_tuser[0] !== want.parallel_flag)
          report_mismatch("parallel_flag", m_axis_tuser[0], want.parallel_flag);
        if (want.parallel_flag) parallel_seen++;
      end
      checked++;
    end
  end

  always @(posedge clk) begin
    if (hold_off) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_word(track_wire_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= pack_item(it);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_q.push_back(closest_approach(it, threshold));
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    threshold = v;
    @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 4095) - 2048);
      2: return ($urandom_range(1)) ? coord_t'(24'h7fffff) : coord_t'(24'h800000);
      default: return coord_t'($urandom_range(0, 255) - 128);
    endcase
  endfunction

  function automatic track_wire_t random_item();
    track_wire_t it;
    int mode = $urandom_range(3);
    for (int k = 0; k < 12; k++) it.f[k] = rand_coord($urandom_range(9) == 0 ? 0 : mode);
    case ($urandom_range(7))
      0: for (int k = 0; k < 3; k++) it.f[9+k] = 0;
      1: for (int k = 0; k < 3; k++) it.f[9+k] = it.f[3+k] - it.f[k];
      2: for (int k = 0; k < 3; k++) it.f[3+k] = it.f[k];
      default: ;
    endcase
    return it;
  endfunction

  function automatic row_t make_row(coord_t v[12], logic typed, approach_t want);
    row_t r;
    for (int k = 0; k < 12; k++) r.item.f[k] = v[k];
    r.check_typed = typed;
    r.typed = want;
    return r;
  endfunction

  initial begin
    coord_t mx = 24'h7fffff;
    coord_t mn = 24'h800000;
    approach_t want;
    rows.push_back(make_row('{0,0,0, 0,0,0, 0,0,0, 0,0,0}, 1, '{HALF, ONE, 1}));
    rows.push_back(make_row('{mx,mx,mx, mn,mn,mn, 0,0,0, 0,0,0}, 1, '{HALF, ONE, 1}));
    rows.push_back(make_row('{mn,mn,mn, mx,mx,mx, mx,mn,mx, mx,mx,mx}, 1, '{HALF, 0, 1}));
    rows.push_back(make_row('{0,0,0, 16,0,0, 8,-5,0, 0,0,16}, 1, '{HALF, 0, 0}));
    rows.push_back(make_row('{0,0,0, 16,0,0, 8,-5,0, 0,16,0}, 0, want));
    rows.push_back(make_row('{0,0,0, 16,0,0, 8,-5,-20, 0,0,16}, 0, want));
    rows.push_back(make_row('{0,0,0, 16,0,0, 40,-5,-3, 0,0,16}, 0, want));
    rows.push_back(make_row('{0,0,0, 16,0,0, -40,-5,-30, 0,0,16}, 0, want));
    rows.push_back(make_row('{0,0,0, 16,0,0, 0,5,0, 32,0,0}, 0, want));
    rows.push_back(make_row('{0,0,0, 16,16,0, 5,0,-3, 1,1,16}, 0, want));
    rows.push_back(make_row('{mx,mx,mx, mn,mn,mn, mn,mx,mn, mn,mx,mn}, 0, want));
    rows.push_back(make_row('{mn,mx,mn, mx,mn,mx, mx,mx,mn, mx,mn,mn}, 0, want));
    rows.push_back(make_row('{1,2,3, 1,2,3, -7,9,4, 3,-2,5}, 0, want));
    rows.push_back(make_row('{-1,-1,-1, -1,-1,-1, -1,-1,-1, -1,-1,-1}, 0, want));
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].check_typed &&
          closest_approach(rows[i].item, threshold) != rows[i].typed)
        report_mismatch("table row", i, 0);
      send_word(rows[i].item);
    end
    drain();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 52; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 52; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      case (phase)
        0: write_threshold(32'hffffffff);
        1: write_threshold(32'd0);
        2: write_threshold($urandom_range(1, 100000));
        3: write_threshold(32'h0000ffff);
        4: write_threshold($urandom);
        default: write_threshold(phase == 7 ? 32'd0 : $urandom_range(0, 4096));
      endcase
      if (phase == 4) begin
        fork
          begin
            hold_off = 1;
            for (int n = 0; n < 200; n++) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int n = 0; n < N_RANDOM / 8; n++) send_word(random_item());
      drain();
    end
    $display("Checked %0d results over eight idling and threshold phases,", checked);
    $display("%0d of them on the parallel fallback.", parallel_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
